// File: hdl/abt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Address blacklist table package
// Sizes, entry and control types, command and state codes shared by the
// cell row and the table controller.
// ----------------------------------------------------------------------------
package abt_pkg;

   localparam int ENTRIES    = 64;
   localparam int ADDR_BYTES = 32;
   localparam int TIME_BITS  = 32;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int LEN_W = 6;
   localparam int KEY_W = 256;

   typedef enum logic [2:0] {
      CMD_CHECK = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_CLEAR = 3'd2,
      CMD_COUNT = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0]     len;
      logic [KEY_W-1:0]     key;
      logic [TIME_BITS-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic wr_all;
      logic wr_stamp;
   } cell_ctl_type;

   function automatic logic [TIME_BITS-1:0] to_stamp(input logic [31:0] s);
      logic [63:0] t;
      t = {32'b0, s};
      return t[TIME_BITS-1:0];
   endfunction

   function automatic logic [6:0] to_count7(input logic [CNT_W-1:0] c);
      logic [63:0] t;
      t = 64'(c);
      return t[6:0];
   endfunction

endpackage
`default_nettype wire

// File: hdl/abt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Table cell
// Holds one entry. During a scan it takes the entry of its neighbor so the
// row rotates; outside a scan it can be loaded whole or get a new stamp.
// ----------------------------------------------------------------------------
module abt_cell
   import abt_pkg::*;
(
   input  wire          clock,
   input  cell_ctl_type ctl,
   input  entry_type    nbr,
   input  entry_type    wr_data,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = nbr;
      end else if (ctl.wr_all) begin
         entry_in = wr_data;
      end else if (ctl.wr_stamp) begin
         entry_in.stamp = wr_data.stamp;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// File: hdl/address_blacklist_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Address blacklist table
// Holds up to ENTRIES addresses with length and time stamp; check, add with
// oldest-entry replacement, clear, count and read of one entry.
// ----------------------------------------------------------------------------
// The entries sit in a ring of cells that rotates by one place per cycle
// during a scan, so every entry passes the comparator at cell zero once.
// Check, add and read entry scan the whole ring; add then updates the
// table. Clear, count, bad lengths, bad indexes and unknown commands go
// straight to the response state. The block takes one command at a
// time; a finished result waits in the output register while the next
// command is accepted. No clearing pass is needed after reset.
module address_blacklist_table
   import abt_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_command,
   input  wire  [5:0]  req_addr_len,
   input  wire  [63:0] req_addr_w0,
   input  wire  [63:0] req_addr_w1,
   input  wire  [63:0] req_addr_w2,
   input  wire  [63:0] req_addr_w3,
   input  wire  [31:0] req_now_seconds,
   input  wire  [5:0]  req_entry_index,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_hit,
   output logic [6:0]  rsp_entry_count,
   output logic        rsp_status,
   output logic [5:0]  rsp_out_len,
   output logic [63:0] rsp_out_w0,
   output logic [63:0] rsp_out_w1,
   output logic [63:0] rsp_out_w2,
   output logic [63:0] rsp_out_w3
);

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL      = CNT_W'(ENTRIES);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]     step_ff, step_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [5:0]           idx_ff, idx_in;
   logic                 status_ff, status_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     match_ff, match_in;
   logic [TIME_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]     oldest_ff, oldest_in;
   entry_type            rd_ff, rd_in;

   logic                 rsp_hit_ff, rsp_hit_in;
   logic [6:0]           rsp_count_ff, rsp_count_in;
   logic                 rsp_status_ff, rsp_status_in;
   entry_type            rsp_entry_ff, rsp_entry_in;

   logic                 req_acc;
   logic                 len_ok;
   logic                 idx_ok;
   logic [KEY_W-1:0]     raw_key;
   logic [KEY_W-1:0]     masked_key;
   logic                 rsp_load;
   logic [IDX_W-1:0]     wr_target;
   entry_type            wr_data;
   entry_type            head;
   logic                 head_valid;
   logic                 head_match;

   cell_ctl_type         cell_ctl [ENTRIES];
   entry_type            cell_q   [ENTRIES];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign len_ok    = (req_addr_len != 6'd0) && (32'(req_addr_len) <= ADDR_BYTES);
   assign idx_ok    = 32'(req_entry_index) < 32'(count_ff);
   assign raw_key   = {req_addr_w3, req_addr_w2, req_addr_w1, req_addr_w0};

   // Bytes at or beyond the length do not take part in the match.
   always_comb begin
      for (int b = 0; b < KEY_W / 8; b++) begin
         masked_key[8*b +: 8] = (6'(b) < req_addr_len) ? raw_key[8*b +: 8] : 8'd0;
      end
   end

   // Cell row: each cell takes its right neighbor, the last one takes cell zero.
   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      abt_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[k]),
         .nbr     (cell_q[(k + 1) % ENTRIES]),
         .wr_data (wr_data),
         .entry   (cell_q[k])
      );
   end

   assign head       = cell_q[0];
   assign head_valid = CNT_W'(step_ff) < count_ff;
   assign head_match = head_valid && (head.len == len_ff) && (head.key == key_ff);
   assign wr_data    = '{len: len_ff, key: key_ff, stamp: now_ff};

   always_comb begin
      if (found_ff) begin
         wr_target = match_ff;
      end else if (count_ff < FULL) begin
         wr_target = count_ff[IDX_W-1:0];
      end else begin
         wr_target = oldest_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_command)
                  CMD_CHECK, CMD_ADD: state_in = len_ok ? ST_SCAN : ST_RESP;
                  CMD_READ:           state_in = idx_ok ? ST_SCAN : ST_RESP;
                  default:            state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (step_ff == LAST_STEP) begin
               state_in = (cmd_ff == CMD_ADD) ? ST_WRITE : ST_RESP;
            end
         end
         ST_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: cell controls and result load.
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         cell_ctl[k].shift    = (state_ff == ST_SCAN);
         cell_ctl[k].wr_all   = (state_ff == ST_WRITE) && !found_ff &&
                                (wr_target == IDX_W'(k));
         cell_ctl[k].wr_stamp = (state_ff == ST_WRITE) && found_ff &&
                                (wr_target == IDX_W'(k));
      end
      rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   end

   // Datapath next values.
   always_comb begin
      count_in  = count_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      now_in    = now_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      found_in  = found_ff;
      match_in  = match_ff;
      best_in   = best_ff;
      oldest_in = oldest_ff;
      rd_in     = rd_ff;

      if (req_acc) begin
         step_in  = '0;
         cmd_in   = req_command;
         len_in   = req_addr_len;
         key_in   = masked_key;
         now_in   = to_stamp(req_now_seconds);
         idx_in   = req_entry_index;
         found_in = 1'b0;
         case (req_command)
            CMD_CHECK, CMD_ADD: status_in = !len_ok;
            CMD_CLEAR: begin
               status_in = 1'b0;
               count_in  = '0;
            end
            CMD_COUNT: status_in = 1'b0;
            CMD_READ:  status_in = !idx_ok;
            default:   status_in = 1'b1;
         endcase
      end

      if (state_ff == ST_SCAN) begin
         step_in = step_ff + 1'b1;
         if (head_match && !found_ff) begin
            found_in = 1'b1;
            match_in = step_ff;
         end
         // Strict compare keeps the lowest index among equal stamps.
         if ((step_ff == '0) || (head.stamp < best_ff)) begin
            best_in   = head.stamp;
            oldest_in = step_ff;
         end
         if (32'(step_ff) == 32'(idx_ff)) begin
            rd_in = head;
         end
      end

      if ((state_ff == ST_WRITE) && !found_ff && (count_ff < FULL)) begin
         count_in = count_ff + 1'b1;
      end
   end

   // Result register.
   always_comb begin
      rsp_hit_in    = rsp_hit_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      if (rsp_load) begin
         rsp_hit_in    = (cmd_ff == CMD_CHECK) && found_ff;
         rsp_count_in  = to_count7(count_ff);
         rsp_status_in = status_ff;
         rsp_entry_in  = ((cmd_ff == CMD_READ) && !status_ff) ? rd_ff : '0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      match_ff      <= match_in;
      best_ff       <= best_in;
      oldest_ff     <= oldest_in;
      rd_ff         <= rd_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_len     = rsp_entry_ff.len;
   assign rsp_out_w0      = rsp_entry_ff.key[63:0];
   assign rsp_out_w1      = rsp_entry_ff.key[127:64];
   assign rsp_out_w2      = rsp_entry_ff.key[191:128];
   assign rsp_out_w3      = rsp_entry_ff.key[255:192];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count exceeds table size");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result raised outside the response state");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (step_ff == LAST_STEP) |=> state_ff != ST_SCAN)
      else $error("scan ran past the last cell");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_status_ff))
      else $error("hit reported together with an error status");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address blacklist table testbench
// Drives check, add, clear, count, read entry and unused commands through the
// request channel and predicts every reply with a cycle-free model of the
// table, covering match on length and leading bytes, time stamp refresh,
// append, and oldest-entry replacement. Both channels idle at random in
// two of three phases. Replies are compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import abt_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
   localparam int POOL_DEPTH   = 100;
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0]       command;
      logic [5:0]       addr_len;
      logic [KEY_W-1:0] addr;
      logic [31:0]      now_seconds;
      logic [5:0]       entry_index;
   } blacklist_command_type;

   typedef struct packed {
      logic             hit;
      logic [6:0]       entry_count;
      logic             status;
      logic [5:0]       out_len;
      logic [KEY_W-1:0] out_addr;
   } blacklist_reply_type;

   typedef struct packed {
      logic [5:0]       len;
      logic [KEY_W-1:0] key;
   } addr_rec_type;

   class blacklist_scoreboard;
      logic [KEY_W-1:0]     held_key [ENTRIES];
      logic [5:0]           held_len [ENTRIES];
      logic [TIME_BITS-1:0] held_stamp [ENTRIES];
      int unsigned          held_count;
      blacklist_reply_type  pending_replies [$];
      int unsigned failures, commands_noted, replies_checked;
      int unsigned hits, refreshes, evictions, rejected;

      function new();
         wipe_table();
      endfunction

      static function logic [KEY_W-1:0] key_mask(int unsigned len);
         logic [KEY_W-1:0] m;
         m = '0;
         for (int b = 0; b < ADDR_BYTES; b++) begin
            if (b < len) m[8*b +: 8] = 8'hFF;
         end
         return m;
      endfunction

      function void wipe_table();
         for (int i = 0; i < ENTRIES; i++) begin
            held_key[i]   = '0;
            held_len[i]   = '0;
            held_stamp[i] = '0;
         end
         held_count = 0;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void store_entry(int slot, logic [5:0] len, logic [KEY_W-1:0] key,
                                logic [TIME_BITS-1:0] stamp);
         held_key[slot]   = key;
         held_len[slot]   = len;
         held_stamp[slot] = stamp;
      endfunction

      // Works out the reply for one accepted command and updates the table.
      function void note_command(blacklist_command_type c);
         blacklist_reply_type r;
         logic [KEY_W-1:0] key;
         logic [63:0]      wide;
         logic [TIME_BITS-1:0] stamp;
         int unsigned len;
         int match, oldest;
         bit len_ok;
         r = '0;
         commands_noted++;
         len = c.addr_len;
         key = c.addr & key_mask(len);
         len_ok = (len != 0) && (len <= ADDR_BYTES);
         wide = {32'b0, c.now_seconds};
         stamp = wide[TIME_BITS-1:0];
         match = -1;
         if (len_ok) begin
            for (int i = 0; i < held_count; i++) begin
               if (held_len[i] == len && held_key[i] == key) begin
                  match = i;
                  break;
               end
            end
         end
         case (c.command)
            CMD_CHECK: begin
               if (!len_ok) begin
                  r.status = 1'b1;
               end else if (match >= 0) begin
                  r.hit = 1'b1;
                  hits++;
               end
            end
            CMD_ADD: begin
               if (!len_ok) begin
                  r.status = 1'b1;
               end else if (match >= 0) begin
                  held_stamp[match] = stamp;
                  refreshes++;
               end else if (held_count < ENTRIES) begin
                  store_entry(held_count, len, key, stamp);
                  held_count++;
               end else begin
                  // Strict less-than keeps the lowest index among equal stamps.
                  oldest = 0;
                  for (int i = 1; i < ENTRIES; i++) begin
                     if (held_stamp[i] < held_stamp[oldest]) oldest = i;
                  end
                  store_entry(oldest, len, key, stamp);
                  evictions++;
               end
            end
            CMD_CLEAR: wipe_table();
            CMD_COUNT: ;
            CMD_READ: begin
               if (c.entry_index >= held_count) begin
                  r.status = 1'b1;
               end else begin
                  r.out_len  = held_len[c.entry_index];
                  r.out_addr = held_key[c.entry_index];
               end
            end
            default: r.status = 1'b1;
         endcase
         if (r.status) rejected++;
         r.entry_count = 7'(held_count);
         pending_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
         end
      endfunction

      function void check_reply(blacklist_reply_type got);
         blacklist_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("reply beat arrived with no command outstanding");
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         replies_checked++;
         compare_field("hit", 64'(want.hit), 64'(got.hit));
         compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("out_len", 64'(want.out_len), 64'(got.out_len));
         compare_field("out_w0", want.out_addr[63:0], got.out_addr[63:0]);
         compare_field("out_w1", want.out_addr[127:64], got.out_addr[127:64]);
         compare_field("out_w2", want.out_addr[191:128], got.out_addr[191:128]);
         compare_field("out_w3", want.out_addr[255:192], got.out_addr[255:192]);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [5:0]  req_addr_len = '0;
   logic [63:0] req_addr_w0 = '0;
   logic [63:0] req_addr_w1 = '0;
   logic [63:0] req_addr_w2 = '0;
   logic [63:0] req_addr_w3 = '0;
   logic [31:0] req_now_seconds = '0;
   logic [5:0]  req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic [6:0]  rsp_entry_count;
   logic        rsp_status;
   logic [5:0]  rsp_out_len;
   logic [63:0] rsp_out_w0;
   logic [63:0] rsp_out_w1;
   logic [63:0] rsp_out_w2;
   logic [63:0] rsp_out_w3;

   int req_idle_pct = 9;
   int rsp_stall_pct = 75;
   logic [31:0] stamp_clock = '0;
   addr_rec_type addr_pool [$];
   blacklist_scoreboard board = new();

   address_blacklist_table DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_addr_len    (req_addr_len),
      .req_addr_w0     (req_addr_w0),
      .req_addr_w1     (req_addr_w1),
      .req_addr_w2     (req_addr_w2),
      .req_addr_w3     (req_addr_w3),
      .req_now_seconds (req_now_seconds),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .rsp_out_len     (rsp_out_len),
      .rsp_out_w0      (rsp_out_w0),
      .rsp_out_w1      (rsp_out_w1),
      .rsp_out_w2      (rsp_out_w2),
      .rsp_out_w3      (rsp_out_w3)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Timeout: %0d replies still outstanding", board.pending());
      $display("Test completed with failures");
      $finish;
   end

   // Reply side: check an accepted beat, then pick the stall for the next edge.
   always @(posedge clock) begin : reply_side
      blacklist_reply_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.hit         = rsp_hit;
         seen.entry_count = rsp_entry_count;
         seen.status      = rsp_status;
         seen.out_len     = rsp_out_len;
         seen.out_addr    = {rsp_out_w3, rsp_out_w2, rsp_out_w1, rsp_out_w0};
         board.check_reply(seen);
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic blacklist_command_type pack_command(logic [2:0] cmd, logic [5:0] len,
         logic [KEY_W-1:0] key, logic [31:0] now, logic [5:0] idx);
      blacklist_command_type c;
      c.command     = cmd;
      c.addr_len    = len;
      c.addr        = key;
      c.now_seconds = now;
      c.entry_index = idx;
      return c;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      for (int i = 0; i < KEY_W / 32; i++) k[32*i +: 32] = $urandom;
      return k;
   endfunction

   function automatic logic [5:0] random_good_len();
      case ($urandom_range(9))
         0: return 6'd1;
         1: return 6'(ADDR_BYTES);
         2: return 6'd4;
         3: return 6'd16;
         default: return 6'($urandom_range(1, ADDR_BYTES));
      endcase
   endfunction

   // Mostly small steps so that equal stamps are common when the table fills.
   function automatic logic [31:0] next_stamp();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: stamp_clock = stamp_clock + $urandom_range(0, 2);
         6, 7: stamp_clock = $urandom;
         8: stamp_clock = '0;
         default: stamp_clock = '1;
      endcase
      return stamp_clock;
   endfunction

   // Keeps the held bytes of a known address and fills the rest with noise.
   function automatic logic [KEY_W-1:0] with_noise(addr_rec_type rec);
      logic [KEY_W-1:0] m;
      m = blacklist_scoreboard::key_mask(rec.len);
      return (rec.key & m) | (random_key() & ~m);
   endfunction

   function automatic blacklist_command_type random_command();
      int unsigned pick;
      logic [2:0] cmd;
      logic [5:0] len, idx;
      logic [KEY_W-1:0] key;
      logic [31:0] now;
      addr_rec_type rec;
      pick = $urandom_range(999);
      len  = 6'($urandom_range(63));
      key  = random_key();
      now  = $urandom;
      idx  = 6'($urandom_range(63));
      if (addr_pool.size() > 0) rec = addr_pool[$urandom_range(addr_pool.size() - 1)];
      if (pick < 2) begin
         cmd = CMD_CLEAR;
      end else if (pick < 20) begin
         cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end else if (pick < 70) begin
         cmd = $urandom_range(1) ? CMD_ADD : CMD_CHECK;
         len = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(ADDR_BYTES + 1, 63));
      end else if (pick < 150) begin
         cmd = CMD_COUNT;
      end else if (pick < 300) begin
         cmd = CMD_READ;
         if (board.held_count > 0 && $urandom_range(99) < 70)
            idx = 6'($urandom_range(board.held_count - 1));
      end else if (pick < 650) begin
         cmd = CMD_ADD;
         now = next_stamp();
         if (addr_pool.size() > 0 && $urandom_range(99) < 35) begin
            len = rec.len;
            key = with_noise(rec);
         end else begin
            len = random_good_len();
            rec.len = len;
            rec.key = key & blacklist_scoreboard::key_mask(len);
            addr_pool.push_back(rec);
            if (addr_pool.size() > POOL_DEPTH) void'(addr_pool.pop_front());
         end
      end else begin
         cmd = CMD_CHECK;
         pick = $urandom_range(99);
         if (addr_pool.size() > 0 && pick < 60) begin
            len = rec.len;
            key = with_noise(rec);
         end else if (addr_pool.size() > 0 && pick < 80) begin
            // Same leading bytes under a neighboring length must miss.
            len = (rec.len == ADDR_BYTES || (rec.len > 1 && $urandom_range(1))) ?
                  rec.len - 1 : rec.len + 1;
            key = with_noise(rec);
         end else begin
            len = random_good_len();
         end
      end
      return pack_command(cmd, len, key, now, idx);
   endfunction

   task automatic send_command(blacklist_command_type c);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= c.command;
      req_addr_len    <= c.addr_len;
      req_addr_w0     <= c.addr[63:0];
      req_addr_w1     <= c.addr[127:64];
      req_addr_w2     <= c.addr[191:128];
      req_addr_w3     <= c.addr[255:192];
      req_now_seconds <= c.now_seconds;
      req_entry_index <= c.entry_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(c);
   endtask

   task automatic run_directed();
      logic [KEY_W-1:0] ones, noise_a, noise_b;
      ones    = '1;
      noise_a = random_key();
      noise_b = random_key();
      send_command(pack_command(CMD_COUNT, 6'd0, '0, '0, 6'd0));
      send_command(pack_command(CMD_READ, 6'd0, '0, '0, 6'd0));
      send_command(pack_command(CMD_CHECK, 6'd1, noise_a, '0, 6'd0));
      send_command(pack_command(CMD_ADD, 6'd1, noise_a, '0, 6'd0));
      send_command(pack_command(CMD_ADD, 6'(ADDR_BYTES), ones, '1, 6'd63));
      send_command(pack_command(CMD_ADD, 6'd4, noise_b, 32'd5, 6'd0));
      // Only byte zero is held for a one-byte address.
      send_command(pack_command(CMD_CHECK, 6'd1, {noise_b[KEY_W-1:8], noise_a[7:0]},
                                '0, 6'd0));
      send_command(pack_command(CMD_CHECK, 6'd2, noise_a, '0, 6'd0));
      send_command(pack_command(CMD_CHECK, 6'(ADDR_BYTES), ones, '0, 6'd0));
      send_command(pack_command(CMD_ADD, 6'd0, ones, '1, 6'd0));
      send_command(pack_command(CMD_CHECK, 6'(ADDR_BYTES + 1), ones, '0, 6'd0));
      send_command(pack_command(CMD_CHECK, 6'd63, ones, '0, 6'd63));
      send_command(pack_command(CMD_ADD, 6'd4, {noise_a[KEY_W-1:32], noise_b[31:0]},
                                32'd6, 6'd0));
      send_command(pack_command(CMD_READ, 6'd0, ones, '1, 6'd0));
      send_command(pack_command(CMD_READ, 6'd0, '0, '0, 6'd1));
      send_command(pack_command(CMD_READ, 6'd0, '0, '0, 6'd2));
      send_command(pack_command(CMD_READ, 6'd0, '0, '0, 6'd3));
      send_command(pack_command(CMD_READ, 6'd0, '0, '0, 6'd63));
      for (int u = CMD_UNUSED_LO; u <= CMD_UNUSED_HI; u++)
         send_command(pack_command(3'(u), 6'd4, noise_b, '1, 6'd0));
      send_command(pack_command(CMD_COUNT, 6'd63, ones, '1, 6'd63));
      send_command(pack_command(CMD_CLEAR, 6'd4, noise_b, '0, 6'd0));
      send_command(pack_command(CMD_COUNT, 6'd0, '0, '0, 6'd0));
      send_command(pack_command(CMD_READ, 6'd0, '0, '0, 6'd0));
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            req_idle_pct  = 75;
            rsp_stall_pct = 9;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         send_command(random_command());
      end
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d commands and %0d reply beats under three idle patterns.",
               board.commands_noted, board.replies_checked);
      $display("Hits %0d, refreshes %0d, replacements of the oldest %0d, rejected %0d.",
               board.hits, board.refreshes, board.evictions, board.rejected);
      if (board.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/abt_pkg.sv
hdl/abt_cell.sv
hdl/address_blacklist_table.sv
tb/sv/testbench.sv
